// ===== sv/c6502_pkg.sv =====
// Shared types, register indexes and decode helpers for the 6502 execute core.
package c6502_pkg;

  typedef struct packed {
    logic        nmi;
    logic [7:0]  opcode;
    logic [7:0]  operand;
    logic [15:0] target_address;
  } in_word_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        last;
    logic [15:0] next_pc;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
    logic [7:0]  flags_out;
  } out_word_t;

  typedef enum logic [1:0] {
    CfgResetVector = 2'd0,
    CfgBrkVector   = 2'd1,
    CfgNmiVector   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PullNone = 2'd0,
    PullOne  = 2'd1,
    PullTwo  = 2'd2,
    PullThree = 2'd3
  } pull_cnt_e;

  // Front-end classification carried through the queue.
  typedef struct packed {
    in_word_t   item;
    pull_cnt_e  pulls;
    logic [1:0] lenb;
  } cls_t;

  localparam logic [7:0] OpBrk = 8'h00;
  localparam logic [7:0] OpJsr = 8'h20;
  localparam logic [7:0] OpRti = 8'h40;
  localparam logic [7:0] OpRts = 8'h60;
  localparam logic [7:0] OpPlp = 8'h28;
  localparam logic [7:0] OpPla = 8'h68;

  function automatic logic [1:0] op_length(logic [7:0] op);
    logic [1:0] r;
    r = 2'd2;
    case (op[4:0])
      5'h00: begin
        if (op == OpJsr) r = 2'd3;
        else if (op == OpRti || op == OpRts) r = 2'd1;
      end
      5'h08, 5'h0A, 5'h12, 5'h18, 5'h1A: r = 2'd1;
      5'h0C, 5'h0D, 5'h0E, 5'h0F, 5'h19, 5'h1B, 5'h1C, 5'h1D, 5'h1E, 5'h1F: r = 2'd3;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic pull_cnt_e pull_count(logic nmi, logic [7:0] op);
    pull_cnt_e r;
    r = PullNone;
    if (!nmi) begin
      if (op == OpRti) r = PullThree;
      else if (op == OpRts) r = PullTwo;
      else if (op == OpPlp || op == OpPla) r = PullOne;
    end
    return r;
  endfunction

endpackage

// ===== sv/c6502_front.sv =====
// Front end: accepts input words, classifies them and queues them.
module c6502_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_stall,
  input  c6502_pkg::in_word_t in_data,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output c6502_pkg::cls_t     q_data_o
);
  import c6502_pkg::*;

  cls_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cls_t       cls;

  always_comb begin
    cls.item  = in_data;
    cls.pulls = pull_count(in_data.nmi, in_data.opcode);
    cls.lenb  = op_length(in_data.opcode);
  end

  assign in_stall  = (cnt_q == 2'd2);
  assign push      = in_valid && !in_stall;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_pop_i && q_valid_o;
  assign q_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> (cnt_q == 2'd2)) else $error("full queue lost a word");

endmodule

// ===== sv/c6502_back.sv =====
// Back end: pulls stack bytes, executes the instruction and emits result words.
module c6502_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  c6502_pkg::cfg_idx_e  cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  c6502_pkg::cls_t      q_data_i,
  output logic                 out_valid,
  input  logic                 out_stall,
  output c6502_pkg::out_word_t out_data
);
  import c6502_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StPull = 4'b0010,
    StEmit = 4'b0100,
    StHold = 4'b1000
  } st_e;

  st_e         st_q, st_d;
  logic [15:0] brkv_q, nmiv_q;
  logic [7:0]  a_q, x_q, y_q, sp_q;
  logic [6:0]  p_q;
  logic [15:0] pc_q;
  logic [7:0]  stk_q [256];
  logic [7:0]  rd_q;
  logic [1:0]  pn_q;
  logic [7:0]  pb_q [3];

  logic [15:0] wa_q [3];
  logic [7:0]  wd_q [3];
  logic [1:0]  wn_q, wi_q;

  // execution combinational
  in_word_t    it;
  logic [7:0]  op, m, a_n, x_n, y_n, sp_n, pv;
  logic [6:0]  p_n;
  logic [15:0] npc, pc2;
  logic [1:0]  wn;
  logic [15:0] wa [3];
  logic [7:0]  wd [3];
  logic [2:0]  aaa, bbb;
  logic [8:0]  sum;
  logic [7:0]  addm, mr, mv;
  logic        mc, fsel;

  assign it  = q_data_i.item;
  assign op  = it.opcode;
  assign m   = it.operand;
  assign aaa = op[7:5];
  assign bbb = op[4:2];
  assign pc2 = pc_q + 16'd2;

  // p_q bits: 6 N,5 V,4 B,3 D,2 I,1 Z,0 C
  function automatic logic [7:0] p8(logic [6:0] p);
    return {p[6], p[5], 1'b1, p[4:0]};
  endfunction
  function automatic logic [6:0] p7(logic [7:0] b);
    return {b[7], b[6], b[4:0]};
  endfunction

  always_comb begin
    a_n = a_q; x_n = x_q; y_n = y_q; sp_n = sp_q; p_n = p_q;
    npc = pc_q + {14'd0, q_data_i.lenb};
    wn = 2'd0;
    for (int i = 0; i < 3; i++) begin
      wa[i] = 16'd0; wd[i] = 8'd0;
    end
    pv = 8'd0;
    addm = (aaa == 3'd7) ? ~m : m;
    sum = {1'b0, a_q} + {1'b0, addm} + {8'd0, p_q[0]};
    mv = (bbb == 3'd2) ? a_q : m;
    mc = p_q[0];
    case (aaa)
      3'd0: begin mc = mv[7]; mr = {mv[6:0], 1'b0}; end
      3'd1: begin mc = mv[7]; mr = {mv[6:0], p_q[0]}; end
      3'd2: begin mc = mv[0]; mr = {1'b0, mv[7:1]}; end
      3'd3: begin mc = mv[0]; mr = {p_q[0], mv[7:1]}; end
      3'd6: mr = mv - 8'd1;
      default: mr = mv + 8'd1;
    endcase
    case (op[7:6])
      2'd0: fsel = p_q[6];
      2'd1: fsel = p_q[5];
      2'd2: fsel = p_q[0];
      default: fsel = p_q[1];
    endcase
    if (it.nmi) begin
      wn = 2'd3;
      wa[0] = {8'h01, sp_q};         wd[0] = pc_q[15:8];
      wa[1] = {8'h01, sp_q - 8'd1};  wd[1] = pc_q[7:0];
      wa[2] = {8'h01, sp_q - 8'd2};  wd[2] = p8(p_q) & 8'hEF;
      sp_n = sp_q - 8'd3;
      p_n[2] = 1'b1; p_n[4] = 1'b0;
      npc = nmiv_q;
    end else if (op[1:0] == 2'd1) begin
      case (aaa)
        3'd0: a_n = a_q | m;
        3'd1: a_n = a_q & m;
        3'd2: a_n = a_q ^ m;
        3'd3, 3'd7: begin
          a_n = sum[7:0]; p_n[0] = sum[8];
          p_n[5] = (~(a_q[7] ^ addm[7])) & (a_q[7] ^ sum[7]);
        end
        3'd4: if (op != 8'h89) begin wn = 2'd1; wa[0] = it.target_address; wd[0] = a_q; end
        3'd5: a_n = m;
        default: begin
          p_n[0] = a_q >= m; pv = a_q - m;
        end
      endcase
      if (aaa != 3'd4) begin
        if (aaa == 3'd6) begin p_n[1] = pv == 8'd0; p_n[6] = pv[7]; end
        else begin p_n[1] = a_n == 8'd0; p_n[6] = a_n[7]; end
      end
    end else if (op[4:0] == 5'h10) begin
      if (fsel == op[5]) npc = it.target_address;
    end else begin
      case (op)
        8'h00: begin
          wn = 2'd3;
          wa[0] = {8'h01, sp_q};        wd[0] = pc2[15:8];
          wa[1] = {8'h01, sp_q - 8'd1}; wd[1] = pc2[7:0];
          wa[2] = {8'h01, sp_q - 8'd2}; wd[2] = p8(p_q) | 8'h30;
          sp_n = sp_q - 8'd3;
          p_n[2] = 1'b1; p_n[4] = 1'b1;
          npc = brkv_q;
        end
        8'h20: begin
          wn = 2'd2;
          wa[0] = {8'h01, sp_q};        wd[0] = pc2[15:8];
          wa[1] = {8'h01, sp_q - 8'd1}; wd[1] = pc2[7:0];
          sp_n = sp_q - 8'd2;
          npc = it.target_address;
        end
        8'h40: begin
          p_n = p7(pb_q[0]);
          npc = {pb_q[2], pb_q[1]};
          sp_n = sp_q + 8'd3;
        end
        8'h60: begin
          npc = {pb_q[1], pb_q[0]} + 16'd1;
          sp_n = sp_q + 8'd2;
        end
        8'h4C, 8'h6C: npc = it.target_address;
        8'h24, 8'h2C: begin
          p_n[1] = (a_q & m) == 8'd0; p_n[5] = m[6]; p_n[6] = m[7];
        end
        8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: begin
          y_n = m; p_n[1] = m == 8'd0; p_n[6] = m[7];
        end
        8'h84, 8'h8C, 8'h94: begin wn = 2'd1; wa[0] = it.target_address; wd[0] = y_q; end
        8'hC0, 8'hC4, 8'hCC: begin
          pv = y_q - m; p_n[0] = y_q >= m; p_n[1] = pv == 8'd0; p_n[6] = pv[7];
        end
        8'hE0, 8'hE4, 8'hEC: begin
          pv = x_q - m; p_n[0] = x_q >= m; p_n[1] = pv == 8'd0; p_n[6] = pv[7];
        end
        8'h18: p_n[0] = 1'b0;
        8'h38: p_n[0] = 1'b1;
        8'h58: p_n[2] = 1'b0;
        8'h78: p_n[2] = 1'b1;
        8'hB8: p_n[5] = 1'b0;
        8'hD8: p_n[3] = 1'b0;
        8'hF8: p_n[3] = 1'b1;
        8'h08: begin
          wn = 2'd1; wa[0] = {8'h01, sp_q}; wd[0] = p8(p_q) | 8'h30; sp_n = sp_q - 8'd1;
        end
        8'h28: begin p_n = p7(pb_q[0]); sp_n = sp_q + 8'd1; end
        8'h48: begin wn = 2'd1; wa[0] = {8'h01, sp_q}; wd[0] = a_q; sp_n = sp_q - 8'd1; end
        8'h68: begin
          a_n = pb_q[0]; sp_n = sp_q + 8'd1; p_n[1] = a_n == 8'd0; p_n[6] = a_n[7];
        end
        8'hE8, 8'hCA, 8'hAA, 8'hBA: begin
          if (op == 8'hE8) x_n = x_q + 8'd1;
          else if (op == 8'hCA) x_n = x_q - 8'd1;
          else if (op == 8'hAA) x_n = a_q;
          else x_n = sp_q;
          p_n[1] = x_n == 8'd0; p_n[6] = x_n[7];
        end
        8'hC8, 8'h88, 8'hA8: begin
          if (op == 8'hC8) y_n = y_q + 8'd1;
          else if (op == 8'h88) y_n = y_q - 8'd1;
          else y_n = a_q;
          p_n[1] = y_n == 8'd0; p_n[6] = y_n[7];
        end
        8'h8A, 8'h98: begin
          a_n = (op == 8'h8A) ? x_q : y_q;
          p_n[1] = a_n == 8'd0; p_n[6] = a_n[7];
        end
        8'h9A: sp_n = x_q;
        default: begin
          if (op[1:0] == 2'd2) begin
            if (!aaa[2] || aaa == 3'd6 || aaa == 3'd7) begin
              if ((bbb == 3'd2 && !aaa[2]) || bbb[0]) begin
                if (!aaa[2]) p_n[0] = mc;
                p_n[1] = mr == 8'd0; p_n[6] = mr[7];
                if (bbb == 3'd2) a_n = mr;
                else begin wn = 2'd1; wa[0] = it.target_address; wd[0] = mr; end
              end
            end else if (aaa == 3'd4) begin
              if (bbb == 3'd1 || bbb == 3'd3 || bbb == 3'd5) begin
                wn = 2'd1; wa[0] = it.target_address; wd[0] = x_q;
              end
            end else begin
              if (bbb == 3'd0 || bbb[0]) begin
                x_n = m; p_n[1] = m == 8'd0; p_n[6] = m[7];
              end
            end
          end
        end
      endcase
    end
  end

  logic go, pull_rd, pend;
  logic [2:0] pdone;
  logic [7:0] pull_addr;
  assign pend      = (st_q == StPull);
  assign pdone     = {1'b0, pn_q} + {2'd0, pend};
  assign pull_rd   = (st_q == StIdle || st_q == StPull) && q_valid_i &&
                     (pdone < {1'b0, q_data_i.pulls});
  assign pull_addr = sp_q + {6'd0, pn_q} + {7'd0, pend} + 8'd1;
  assign go = (st_q == StIdle) && q_valid_i && (pn_q == q_data_i.pulls);
  assign q_pop_o = go;

  always_ff @(posedge clk_i) begin
    if (pull_rd) rd_q <= stk_q[pull_addr];
    if (st_q == StEmit && wn_q != 2'd0 && wa_q[wi_q][15:8] == 8'h01)
      stk_q[wa_q[wi_q][7:0]] <= wd_q[wi_q];
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle, StPull: begin
        if (go) st_d = StEmit;
        else if (pull_rd) st_d = StPull;
        else st_d = StIdle;
      end
      StEmit: if (!out_stall && wi_q + 2'd1 >= wn_q) st_d = StIdle;
      StHold: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      a_q <= 8'd0; x_q <= 8'd0; y_q <= 8'd0; sp_q <= 8'hFF; p_q <= 7'd0;
      pc_q <= 16'd0; brkv_q <= 16'd0; nmiv_q <= 16'd0;
      pn_q <= 2'd0; wn_q <= 2'd0; wi_q <= 2'd0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgResetVector: pc_q <= cfg_data_i;
          CfgBrkVector:   brkv_q <= cfg_data_i;
          CfgNmiVector:   nmiv_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (st_q == StPull) begin
        pb_q[pn_q] <= rd_q;
        pn_q <= pn_q + 2'd1;
      end
      if (go) begin
        a_q <= a_n; x_q <= x_n; y_q <= y_n; sp_q <= sp_n; p_q <= p_n; pc_q <= npc;
        pn_q <= 2'd0;
        wn_q <= wn; wi_q <= 2'd0;
        for (int i = 0; i < 3; i++) begin wa_q[i] <= wa[i]; wd_q[i] <= wd[i]; end
      end else if (st_q == StEmit && !out_stall) begin
        wi_q <= wi_q + 2'd1;
      end
    end
  end

  always_comb begin
    out_data.write_valid   = wn_q != 2'd0;
    out_data.write_address = (wn_q != 2'd0) ? wa_q[wi_q] : 16'd0;
    out_data.write_data    = (wn_q != 2'd0) ? wd_q[wi_q] : 8'd0;
    out_data.last          = (wi_q + 2'd1 >= wn_q);
    out_data.next_pc       = pc_q;
    out_data.acc_out       = a_q;
    out_data.x_out         = x_q;
    out_data.y_out         = y_q;
    out_data.sp_out        = sp_q;
    out_data.flags_out     = p8(p_q);
  end
  assign out_valid = (st_q == StEmit);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |-> (st_q != StEmit)) else $error("execute while emitting");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (wi_q < 2'd3)) else $error("write index out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_stall && out_data.last) |=> !out_valid)
    else $error("extra word after last");

endmodule

// ===== sv/cpu_6502_execute_core.sv =====
// Top level of the 6502 execute core: front queue and back-end executor.
//  channel | direction | handshake
//  in      | input     | in_valid / in_stall, word c6502_pkg::in_word_t
//  out     | output    | out_valid / out_stall, word c6502_pkg::out_word_t
//  cfg     | input     | cfg_valid / cfg_ready, index and 16-bit data
// An instruction first pulls its stack bytes one at a time, then executes, then
// emits one output word per stack or memory write (at least one word).
// Stack pulls are read through the registered stack store port.
// Reset zeroes A, X, Y, the flags and PC and sets SP to FF.
// Either side may stall; the two-entry front queue decouples them.
module cpu_6502_execute_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  c6502_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output c6502_pkg::out_word_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import c6502_pkg::*;

  logic q_valid, q_pop;
  cls_t q_data;

  assign cfg_ready = 1'b1;

  c6502_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_data,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  c6502_back u_back (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_valid && cfg_ready), .cfg_idx_i(cfg_idx_e'(cfg_index)),
    .cfg_data_i(cfg_data),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid, .out_stall, .out_data
  );

endmodule
